// File: hdl/wesm_pkg.sv
// Shared widths, constants, codes and types of the wheel encoder speed meter.
`default_nettype none

package wesm_pkg;

  localparam int unsigned TIME_BITS      = 48;
  localparam int unsigned COUNT_BITS     = 24;
  localparam int unsigned PPR_BITS       = 16;
  localparam int unsigned GEAR_BITS      = 16;
  localparam int unsigned DIA_BITS       = 24;
  localparam int unsigned PER_BITS       = 56;
  localparam int unsigned RATE_BITS      = 32;
  localparam int unsigned PI_BITS        = 18;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 24;

  localparam int unsigned DIV_NUM_BITS = 72;
  localparam int unsigned DIV_DEN_BITS = 56;
  localparam int unsigned DIV_CNT_BITS = 7;

  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // Pi in Q16 and sixty million microseconds in Q16.
  localparam logic [PI_BITS-1:0] PI_Q16           = 18'd205887;
  localparam logic [41:0]        USEC_PER_MIN_Q16 = 42'd3932160000000;

  localparam logic [PPR_BITS-1:0]  PPR_RESET  = 16'd1;
  localparam logic [GEAR_BITS-1:0] GEAR_RESET = 16'd256;
  localparam logic [DIA_BITS-1:0]  DIA_RESET  = 24'd256;

  typedef enum logic {
    KIND_EDGE    = 1'b0,
    KIND_COLLECT = 1'b1
  } item_kind_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PPR  = 2'd0,
    CFG_GEAR = 2'd1,
    CFG_DIA  = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_PULSE,
    BS_REV_MUL,
    BS_REV,
    BS_MOTOR,
    BS_WHEEL,
    BS_RPS,
    BS_PI_MUL,
    BS_DIA_LO,
    BS_DIA_HI,
    BS_FINISH,
    BS_OUT
  } back_state_e;

  typedef struct packed {
    logic [PPR_BITS-1:0]  ppr;
    logic [GEAR_BITS-1:0] gear;
    logic [DIA_BITS-1:0]  dia;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  start_time_us;
    logic [TIME_BITS-1:0]  end_time_us;
    logic [TIME_BITS-1:0]  elapsed_us;
    logic [COUNT_BITS-1:0] pulse_total;
  } snap_t;

  typedef struct packed {
    logic                    start;
    logic [DIV_NUM_BITS-1:0] num;
    logic [DIV_DEN_BITS-1:0] den;
    logic [DIV_CNT_BITS-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [DIV_NUM_BITS-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hdl/wesm_if.sv
// Channel interfaces: encoder items, configuration writes and results.
`default_nettype none

interface wesm_item_if;
  import wesm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [TIME_BITS-1:0] timestamp_us;

  modport source (output valid, output kind, output timestamp_us, input ready);
  modport sink (input valid, input kind, input timestamp_us, output ready);
endinterface

interface wesm_cfg_if;
  import wesm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface wesm_result_if;
  import wesm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [TIME_BITS-1:0]  start_time_us;
  logic [TIME_BITS-1:0]  end_time_us;
  logic [TIME_BITS-1:0]  elapsed_us;
  logic [COUNT_BITS-1:0] pulse_total;
  logic [PER_BITS-1:0]   us_per_pulse_q8;
  logic [PER_BITS-1:0]   us_per_rev_q8;
  logic [RATE_BITS-1:0]  motor_rpm_q8;
  logic [RATE_BITS-1:0]  wheel_rpm_q8;
  logic [RATE_BITS-1:0]  wheel_rps_q8;
  logic [RATE_BITS-1:0]  speed_mm_s_q8;

  modport source (
    output valid, output start_time_us, output end_time_us, output elapsed_us,
    output pulse_total, output us_per_pulse_q8, output us_per_rev_q8,
    output motor_rpm_q8, output wheel_rpm_q8, output wheel_rps_q8,
    output speed_mm_s_q8, input ready
  );
  modport sink (
    input valid, input start_time_us, input end_time_us, input elapsed_us,
    input pulse_total, input us_per_pulse_q8, input us_per_rev_q8,
    input motor_rpm_q8, input wheel_rpm_q8, input wheel_rps_q8,
    input speed_mm_s_q8, output ready
  );
endinterface

`default_nettype wire

// File: hdl/wesm_front.sv
// Front end: counts encoder edges and snapshots the window on a collect request.
`default_nettype none

module wesm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  wesm_item_if.sink       item_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output wesm_pkg::snap_t push_data_o
);
  import wesm_pkg::*;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [TIME_BITS-1:0]  last_q, last_d;
  logic [TIME_BITS-1:0]  start_q, start_d;
  logic                  is_collect;
  logic                  accept;

  assign is_collect   = (item_i.kind == KIND_COLLECT);
  // Edges never wait on the queue; only a collect needs room in it.
  assign item_i.ready = !is_collect || push_ready_i;
  assign accept       = item_i.valid && item_i.ready;
  assign push_valid_o = item_i.valid && is_collect;

  assign push_data_o.start_time_us = start_q;
  assign push_data_o.end_time_us   = last_q;
  assign push_data_o.elapsed_us    = last_q - start_q;
  assign push_data_o.pulse_total   = count_q;

  always_comb begin
    count_d = count_q;
    last_d  = last_q;
    start_d = start_q;
    if (accept) begin
      if (is_collect) begin
        start_d = last_q;
        count_d = '0;
      end else begin
        if (count_q != '1) begin
          count_d = count_q + 1'b1;
        end
        last_d = item_i.timestamp_us;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      last_q  <= '0;
      start_q <= '0;
    end else begin
      count_q <= count_d;
      last_q  <= last_d;
      start_q <= start_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/wesm_queue.sv
// Short queue of window snapshots between the front end and the rate engine.
`default_nettype none

module wesm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  wesm_pkg::snap_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output wesm_pkg::snap_t pop_data_o
);
  import wesm_pkg::*;

  snap_t                     mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_BITS-1:0] fill_q, fill_d;
  logic                      push;
  logic                      pop;

  assign push_ready_o = (fill_q != QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/wesm_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module wesm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wesm_pkg::div_req_t req_i,
  output wesm_pkg::div_rsp_t rsp_o
);
  import wesm_pkg::*;

  logic                    busy_q;
  logic                    done_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic [DIV_DEN_BITS-1:0] rem_q;
  logic [DIV_NUM_BITS-1:0] num_q;
  logic [DIV_DEN_BITS-1:0] den_q;
  logic [DIV_DEN_BITS:0]   trial;
  logic                    fits;

  // The numerator arrives left-aligned, so after the requested number of
  // steps the shift register holds exactly the quotient.
  assign trial = {rem_q, num_q[DIV_NUM_BITS-1]};
  assign fits  = (trial >= {1'b0, den_q});

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_BITS'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_BITS'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      num_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= fits ? DIV_DEN_BITS'(trial - {1'b0, den_q}) : trial[DIV_DEN_BITS-1:0];
      num_q <= {num_q[DIV_NUM_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: hdl/wesm_back.sv
// Rate engine: turns one window snapshot into the timing and speed figures.
`default_nettype none

module wesm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wesm_pkg::cfg_t     cfg_i,
  input  logic               snap_valid_i,
  output logic               snap_ready_o,
  input  wesm_pkg::snap_t    snap_i,
  output wesm_pkg::div_req_t div_req_o,
  input  wesm_pkg::div_rsp_t div_rsp_i,
  wesm_result_if.source      result_o
);
  import wesm_pkg::*;

  localparam logic [DIV_CNT_BITS-1:0] STEPS_PULSE = 7'd56;
  localparam logic [DIV_CNT_BITS-1:0] STEPS_REV   = 7'd72;
  localparam logic [DIV_CNT_BITS-1:0] STEPS_MOTOR = 7'd42;
  localparam logic [DIV_CNT_BITS-1:0] STEPS_WHEEL = 7'd40;
  localparam logic [RATE_BITS-1:0]    RPS_RECIP   = 32'h8888_8889;
  localparam int unsigned             RPS_SHIFT   = 37;

  back_state_e state_q, state_d;
  logic        started_q;
  logic        is_div;

  snap_t                 snap_q;
  logic [PER_BITS-1:0]   pulse_q;
  logic [PER_BITS-1:0]   rev_q;
  logic [RATE_BITS-1:0]  motor_q;
  logic [RATE_BITS-1:0]  wheel_q;
  logic [RATE_BITS-1:0]  rps_q;
  logic [RATE_BITS-1:0]  speed_q;
  logic [63:0]           prod_q;
  logic [49:0]           x_q;
  logic [73:0]           acc_q;
  logic [24:0]           dia_mul_a;
  logic [48:0]           dia_prod;
  logic [63:0]           rps_prod;

  assign is_div = (state_q == BS_PULSE) || (state_q == BS_REV) || (state_q == BS_MOTOR)
               || (state_q == BS_WHEEL);

  // The 50 by 24 bit speed product is taken in two halves on one multiplier.
  assign dia_mul_a = (state_q == BS_DIA_HI) ? x_q[49:25] : x_q[24:0];
  assign dia_prod  = 49'(dia_mul_a) * 49'(cfg_i.dia);

  // Division by sixty is a multiplication by the rounded-up reciprocal of
  // sixty scaled by 2^37, which is exact for every 32-bit rate.
  assign rps_prod = 64'(wheel_q) * 64'(RPS_RECIP);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (snap_valid_i) begin
          state_d = (snap_i.pulse_total == '0) ? BS_OUT : BS_PULSE;
        end
      end
      BS_PULSE:   if (div_rsp_i.done) state_d = BS_REV_MUL;
      BS_REV_MUL: state_d = BS_REV;
      BS_REV:     if (div_rsp_i.done) state_d = BS_MOTOR;
      BS_MOTOR:   if (div_rsp_i.done) state_d = BS_WHEEL;
      BS_WHEEL:   if (div_rsp_i.done) state_d = BS_RPS;
      BS_RPS:     state_d = BS_PI_MUL;
      BS_PI_MUL:  state_d = BS_DIA_LO;
      BS_DIA_LO:  state_d = BS_DIA_HI;
      BS_DIA_HI:  state_d = BS_FINISH;
      BS_FINISH:  state_d = BS_OUT;
      BS_OUT:     if (result_o.ready) state_d = BS_IDLE;
      default:    state_d = BS_IDLE;
    endcase
  end

  always_comb begin
    snap_ready_o    = (state_q == BS_IDLE);
    result_o.valid  = (state_q == BS_OUT);
    div_req_o.start = is_div && !started_q;
    div_req_o.num   = '0;
    div_req_o.den   = '0;
    div_req_o.steps = '0;
    unique case (state_q)
      BS_PULSE: begin
        div_req_o.num   = {snap_q.elapsed_us, 24'd0};
        div_req_o.den   = {32'd0, snap_q.pulse_total};
        div_req_o.steps = STEPS_PULSE;
      end
      BS_REV: begin
        div_req_o.num   = {prod_q, 8'd0};
        div_req_o.den   = {32'd0, snap_q.pulse_total};
        div_req_o.steps = STEPS_REV;
      end
      BS_MOTOR: begin
        div_req_o.num   = {USEC_PER_MIN_Q16, 30'd0};
        div_req_o.den   = rev_q;
        div_req_o.steps = STEPS_MOTOR;
      end
      BS_WHEEL: begin
        div_req_o.num   = {motor_q, 40'd0};
        div_req_o.den   = {40'd0, cfg_i.gear};
        div_req_o.steps = STEPS_WHEEL;
      end
      default: begin
        div_req_o.num = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_IDLE;
      started_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_rsp_i.done) begin
        started_q <= 1'b0;
      end else if (div_req_o.start) begin
        started_q <= 1'b1;
      end
    end
  end

  // A zero divisor drives the divider to an all-ones quotient, which the
  // saturation below turns into the required all-ones rate.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BS_IDLE: begin
        if (snap_valid_i) begin
          snap_q  <= snap_i;
          pulse_q <= '0;
          rev_q   <= '0;
          motor_q <= '0;
          wheel_q <= '0;
          rps_q   <= '0;
          speed_q <= '0;
        end
      end
      BS_PULSE: begin
        if (div_rsp_i.done) pulse_q <= div_rsp_i.quot[PER_BITS-1:0];
      end
      BS_REV_MUL: prod_q <= 64'(snap_q.elapsed_us) * 64'(cfg_i.ppr);
      BS_REV: begin
        if (div_rsp_i.done) begin
          rev_q <= (|div_rsp_i.quot[71:56]) ? '1 : div_rsp_i.quot[PER_BITS-1:0];
        end
      end
      BS_MOTOR: begin
        if (div_rsp_i.done) begin
          motor_q <= (|div_rsp_i.quot[41:32]) ? '1 : div_rsp_i.quot[RATE_BITS-1:0];
        end
      end
      BS_WHEEL: begin
        if (div_rsp_i.done) begin
          wheel_q <= (|div_rsp_i.quot[39:32]) ? '1 : div_rsp_i.quot[RATE_BITS-1:0];
        end
      end
      BS_RPS: rps_q <= RATE_BITS'(rps_prod >> RPS_SHIFT);
      BS_PI_MUL: x_q <= 50'(rps_q) * 50'(PI_Q16);
      BS_DIA_LO: acc_q <= {25'd0, dia_prod};
      BS_DIA_HI: acc_q <= acc_q + {dia_prod, 25'd0};
      BS_FINISH: speed_q <= (|acc_q[73:56]) ? '1 : acc_q[55:24];
      default: begin
        speed_q <= speed_q;
      end
    endcase
  end

  assign result_o.start_time_us   = snap_q.start_time_us;
  assign result_o.end_time_us     = snap_q.end_time_us;
  assign result_o.elapsed_us      = snap_q.elapsed_us;
  assign result_o.pulse_total     = snap_q.pulse_total;
  assign result_o.us_per_pulse_q8 = pulse_q;
  assign result_o.us_per_rev_q8   = rev_q;
  assign result_o.motor_rpm_q8    = motor_q;
  assign result_o.wheel_rpm_q8    = wheel_q;
  assign result_o.wheel_rps_q8    = rps_q;
  assign result_o.speed_mm_s_q8   = speed_q;

endmodule

`default_nettype wire

// File: hdl/wheel_encoder_speed_meter.sv
// Top level of the wheel encoder speed meter with its configuration registers.
//
// One encoder channel; instantiate twice for a left and a right wheel. An edge
// request is always accepted and updates the saturating pulse count and
// the last edge time. A collect request snapshots the window, restarts it at the
// last edge time and queues the snapshot (two deep) for the rate engine, so edges
// keep flowing while figures are worked out. The rate engine handles one window
// at a time; its work is dominated by four divisions on a shared divider that
// yields one quotient bit per cycle (56, 72, 42 and 40 bits); the division by
// sixty is a single reciprocal multiplication. A window with no pulses skips
// the divisions and goes from the idle state straight to the output state.
// Rates are unsigned Q.8 and truncated; configuration writes are accepted in
// every cycle and should only be made while the block is idle.
`default_nettype none

module wheel_encoder_speed_meter (
  input  logic          clk_i,
  input  logic          rst_ni,
  wesm_item_if.sink     item_i,
  wesm_cfg_if.sink      cfg_i,
  wesm_result_if.source result_o
);
  import wesm_pkg::*;

  cfg_t     cfg_q;
  logic     push_valid;
  logic     push_ready;
  snap_t    push_data;
  logic     pop_valid;
  logic     pop_ready;
  snap_t    pop_data;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ppr  <= PPR_RESET;
      cfg_q.gear <= GEAR_RESET;
      cfg_q.dia  <= DIA_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PPR:  cfg_q.ppr  <= cfg_i.data[PPR_BITS-1:0];
        CFG_GEAR: cfg_q.gear <= cfg_i.data[GEAR_BITS-1:0];
        CFG_DIA:  cfg_q.dia  <= cfg_i.data[DIA_BITS-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  wesm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  wesm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  wesm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  wesm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .snap_valid_i (pop_valid),
    .snap_ready_o (pop_ready),
    .snap_i       (pop_data),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire

// File: tb/tb_wheel_encoder_speed_meter.sv
// Self-checking testbench of the wheel encoder speed meter with its own rate predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb_wheel_encoder_speed_meter;
  import wesm_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
  localparam logic [TIME_BITS-1:0]      MAX_STAMP = '1;
  localparam int unsigned               SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [TIME_BITS-1:0]  start_time_us;
    logic [TIME_BITS-1:0]  end_time_us;
    logic [TIME_BITS-1:0]  elapsed_us;
    logic [COUNT_BITS-1:0] pulse_total;
    logic [PER_BITS-1:0]   us_per_pulse_q8;
    logic [PER_BITS-1:0]   us_per_rev_q8;
    logic [RATE_BITS-1:0]  motor_rpm_q8;
    logic [RATE_BITS-1:0]  wheel_rpm_q8;
    logic [RATE_BITS-1:0]  wheel_rps_q8;
    logic [RATE_BITS-1:0]  speed_mm_s_q8;
  } window_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wesm_item_if   item_if ();
  wesm_cfg_if    cfg_if ();
  wesm_result_if result_if ();

  wheel_encoder_speed_meter u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .cfg_i    (cfg_if),
    .result_o (result_if)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state and its copy of the registers.
  logic [PPR_BITS-1:0]   ppr_setting;
  logic [GEAR_BITS-1:0]  gear_setting;
  logic [DIA_BITS-1:0]   dia_setting;
  logic [COUNT_BITS-1:0] odo_count;
  logic [TIME_BITS-1:0]  odo_last_stamp;
  logic [TIME_BITS-1:0]  odo_window_start;

  window_report_t pending_reports[$];
  window_report_t seen_report;
  window_report_t wanted_report;

  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;
  logic [TIME_BITS-1:0] stamp_now;

  function automatic logic [127:0] clamp(logic [127:0] v, int unsigned bits);
    logic [127:0] top;
    top = (128'd1 << bits) - 128'd1;
    return (v > top) ? top : v;
  endfunction

  // Works out the report of the current window and restarts it at the last edge.
  function automatic window_report_t close_window();
    window_report_t rep;
    logic [127:0]   quot;
    rep = '0;
    rep.start_time_us = odo_window_start;
    rep.end_time_us   = odo_last_stamp;
    rep.elapsed_us    = odo_last_stamp - odo_window_start;
    rep.pulse_total   = odo_count;
    if (odo_count != '0) begin
      quot = (128'(rep.elapsed_us) << 8) / 128'(odo_count);
      rep.us_per_pulse_q8 = PER_BITS'(clamp(quot, PER_BITS));
      quot = ((128'(rep.elapsed_us) * 128'(ppr_setting)) << 8) / 128'(odo_count);
      rep.us_per_rev_q8 = PER_BITS'(clamp(quot, PER_BITS));
      if (rep.us_per_rev_q8 == '0) begin
        rep.motor_rpm_q8 = '1;
      end else begin
        quot = 128'(USEC_PER_MIN_Q16) / 128'(rep.us_per_rev_q8);
        rep.motor_rpm_q8 = RATE_BITS'(clamp(quot, RATE_BITS));
      end
      if (gear_setting == '0) begin
        rep.wheel_rpm_q8 = '1;
      end else begin
        quot = (128'(rep.motor_rpm_q8) << 8) / 128'(gear_setting);
        rep.wheel_rpm_q8 = RATE_BITS'(clamp(quot, RATE_BITS));
      end
      rep.wheel_rps_q8 = rep.wheel_rpm_q8 / 60;
      quot = (128'(rep.wheel_rps_q8) * 128'(PI_Q16) * 128'(dia_setting)) >> 24;
      rep.speed_mm_s_q8 = RATE_BITS'(clamp(quot, RATE_BITS));
    end
    odo_window_start = odo_last_stamp;
    odo_count        = '0;
    return rep;
  endfunction

  function automatic logic [TIME_BITS-1:0] any_stamp();
    return {16'($urandom), $urandom};
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected %h, got %h", field, want, got);
      end
    end
  endfunction

  // Sends one request, with a random gap first, and updates the predictor on acceptance.
  task automatic send_req(input item_kind_e kind, input logic [TIME_BITS-1:0] stamp);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      item_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    item_if.valid        <= 1'b1;
    item_if.kind         <= kind;
    item_if.timestamp_us <= stamp;
    do @(posedge clk_i); while (!item_if.ready);
    if (kind == KIND_EDGE) begin
      if (odo_count != '1) odo_count++;
      odo_last_stamp = stamp;
    end else begin
      pending_reports.push_back(close_window());
    end
  endtask

  // The sender pauses until every report is in and the engine has had time to settle.
  task automatic wait_all_reports();
    item_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (index)
      CFG_PPR:  ppr_setting  = data[PPR_BITS-1:0];
      CFG_GEAR: gear_setting = data[GEAR_BITS-1:0];
      CFG_DIA:  dia_setting  = data[DIA_BITS-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [CFG_DATA_BITS-1:0] ppr,
                               input logic [CFG_DATA_BITS-1:0] gear,
                               input logic [CFG_DATA_BITS-1:0] dia);
    write_reg(CFG_PPR, ppr);
    write_reg(CFG_GEAR, gear);
    write_reg(CFG_DIA, dia);
  endtask

  task automatic test_reset_state();
    // A collect straight after reset sees an empty window at time zero.
    send_req(KIND_COLLECT, any_stamp());
  endtask

  task automatic test_timestamp_extremes();
    send_req(KIND_EDGE, '0);
    send_req(KIND_EDGE, MAX_STAMP);
    send_req(KIND_COLLECT, MAX_STAMP);
    send_req(KIND_COLLECT, '0);
    // The window now starts at the top of the time range, so this edge wraps round.
    send_req(KIND_EDGE, 48'd5);
    send_req(KIND_COLLECT, any_stamp());
  endtask

  task automatic test_zero_elapsed();
    send_req(KIND_EDGE, 48'd5);
    send_req(KIND_EDGE, 48'd5);
    send_req(KIND_COLLECT, any_stamp());
  endtask

  task automatic test_register_extremes();
    wait_all_reports();
    // Upper data bits are set so that the width masking is seen to work.
    set_registers(24'hFF0000, 24'hAB0000, 24'hFFFFFF);
    write_reg(CFG_SPARE, 24'h123456);
    send_req(KIND_EDGE, 48'd1005);
    send_req(KIND_COLLECT, '0);
    wait_all_reports();
    set_registers(24'h5AFFFF, 24'hC3FFFF, 24'h000001);
    send_req(KIND_EDGE, 48'd1005 + (48'd1 << 47));
    send_req(KIND_COLLECT, '0);
    wait_all_reports();
    set_registers(24'h000001, 24'h000001, 24'h000000);
    send_req(KIND_EDGE, 48'h8000_0000_1000);
    send_req(KIND_EDGE, 48'h8000_0000_4321);
    send_req(KIND_COLLECT, '0);
  endtask

  task automatic test_backpressure();
    int unsigned i;
    wait_all_reports();
    set_registers(24'd20, 24'd3 << 8, 24'd65 << 8);
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 3000;
    stamp_now   = any_stamp();
    for (i = 0; i < 8; i++) begin
      stamp_now += TIME_BITS'($urandom_range(1, 5000));
      send_req(KIND_EDGE, stamp_now);
      stamp_now += TIME_BITS'($urandom_range(1, 5000));
      send_req(KIND_EDGE, stamp_now);
      send_req(KIND_COLLECT, any_stamp());
    end
    wait_all_reports();
  endtask

  // Mostly rising edge times with a collect now and then; the rest is scattered noise.
  task automatic run_traffic(input int unsigned count);
    int unsigned i;
    int unsigned pick;
    logic [TIME_BITS-1:0] step;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      case ($urandom_range(3))
        0: step = TIME_BITS'($urandom_range(3));
        1: step = TIME_BITS'($urandom_range(1, 4000));
        2: step = TIME_BITS'($urandom_range(1, 1 << 20));
        default: step = TIME_BITS'($urandom);
      endcase
      if (pick < 12) begin
        send_req(KIND_COLLECT, any_stamp());
      end else if (pick < 92) begin
        stamp_now += step;
        send_req(KIND_EDGE, stamp_now);
      end else begin
        send_req(KIND_EDGE, any_stamp());
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned idle_by_phase[4]  = '{0, 78, 0, 32};
    int unsigned stall_by_phase[4] = '{0, 0, 78, 32};
    for (phase = 0; phase < 4; phase++) begin
      wait_all_reports();
      case (phase)
        1: set_registers(24'($urandom_range(1, 65535)), 24'($urandom_range(1, 65535)),
                         24'($urandom_range(1, 24'hFFFFFF)));
        3: set_registers(24'($urandom), 24'($urandom), 24'($urandom));
        default: set_registers(24'($urandom_range(1, 64)), 24'($urandom_range(64, 2048)),
                               24'($urandom_range(256, 51200)));
      endcase
      idle_pct  = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      stamp_now = any_stamp();
      run_traffic(150);
    end
  endtask

  // Result side: random stalls, and a long hold-off counted here when one is asked for.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        result_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      result_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      seen_report = '{result_if.start_time_us, result_if.end_time_us, result_if.elapsed_us,
                      result_if.pulse_total, result_if.us_per_pulse_q8,
                      result_if.us_per_rev_q8, result_if.motor_rpm_q8,
                      result_if.wheel_rpm_q8, result_if.wheel_rps_q8,
                      result_if.speed_mm_s_q8};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no collect request outstanding");
      end else begin
        wanted_report = pending_reports.pop_front();
        check_field("start_time_us", 64'(wanted_report.start_time_us),
                    64'(seen_report.start_time_us));
        check_field("end_time_us", 64'(wanted_report.end_time_us),
                    64'(seen_report.end_time_us));
        check_field("elapsed_us", 64'(wanted_report.elapsed_us),
                    64'(seen_report.elapsed_us));
        check_field("pulse_total", 64'(wanted_report.pulse_total),
                    64'(seen_report.pulse_total));
        check_field("us_per_pulse_q8", 64'(wanted_report.us_per_pulse_q8),
                    64'(seen_report.us_per_pulse_q8));
        check_field("us_per_rev_q8", 64'(wanted_report.us_per_rev_q8),
                    64'(seen_report.us_per_rev_q8));
        check_field("motor_rpm_q8", 64'(wanted_report.motor_rpm_q8),
                    64'(seen_report.motor_rpm_q8));
        check_field("wheel_rpm_q8", 64'(wanted_report.wheel_rpm_q8),
                    64'(seen_report.wheel_rpm_q8));
        check_field("wheel_rps_q8", 64'(wanted_report.wheel_rps_q8),
                    64'(seen_report.wheel_rps_q8));
        check_field("speed_mm_s_q8", 64'(wanted_report.speed_mm_s_q8),
                    64'(seen_report.speed_mm_s_q8));
      end
    end
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni               = 1'b0;
    item_if.valid        = 1'b0;
    item_if.kind         = KIND_EDGE;
    item_if.timestamp_us = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CFG_PPR;
    cfg_if.data          = '0;
    result_if.ready      = 1'b0;
    ppr_setting          = PPR_RESET;
    gear_setting         = GEAR_RESET;
    dia_setting          = DIA_RESET;
    odo_count            = '0;
    odo_last_stamp       = '0;
    odo_window_start     = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_timestamp_extremes();
    test_zero_elapsed();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    wait_all_reports();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
